>>> hw/rtl/sgk_pkg.sv
// package for the scroll glide speed keep window block
// types, register indexes and constants shared by the divider and core
`timescale 1ns / 1ps
`default_nettype none

package sgk_pkg;

  localparam int unsigned DIV_W    = 48;   // dividend and quotient width
  localparam int unsigned DIV_NW   = 32;   // narrow dividend width
  localparam int unsigned DVSR_W   = 32;   // divisor width
  localparam int unsigned DIVCNT_W = 6;

  localparam logic [6:0]  KIN_RST   = 7'd12;
  localparam logic [15:0] WIN_RST   = 16'd1000;
  localparam logic [15:0] SGAP_RST  = 16'd400;
  localparam logic [15:0] FGAP_RST  = 16'd100;
  localparam logic [6:0]  NOTCH     = 7'd120;
  localparam logic [16:0] ONE_Q16   = 17'h10000;

  // slow fraction round(k*65536/120) for k below 120 is (k*SLOW_RECIP + 2^15) >> 16
  localparam logic [31:0] SLOW_RECIP = 32'd35791395;

  typedef enum logic [1:0] {
    CFG_KINETIC = 2'd0,
    CFG_WINDOW  = 2'd1,
    CFG_SLOWGAP = 2'd2,
    CFG_FASTGAP = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    REQ_EVENT = 1'b0,
    REQ_TICK  = 1'b1
  } req_type_e;

  typedef struct packed {
    logic start;
    logic wide;   // 48 steps instead of 32
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/sgk_if.sv
// valid/ready channel interfaces for the event/tick input and the result output
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface sgk_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] event_deltas;

  modport source (output valid, output req_type, output event_deltas, input ready);
  modport sink   (input valid, input req_type, input event_deltas, output ready);
endinterface

interface sgk_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] delivered_units;
  logic [16:0] keep_applied;
  logic        still_active;

  modport source (output valid, output delivered_units, output keep_applied,
                  output still_active, input ready);
  modport sink   (input valid, input delivered_units, input keep_applied,
                  input still_active, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sgk_div.sv
// shared restoring divider, one quotient bit per cycle, 32 or 48 steps
// depends on sgk_pkg
`timescale 1ns / 1ps
`default_nettype none

module sgk_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire sgk_pkg::div_req_t           req_i,
  input  wire logic [sgk_pkg::DIV_W-1:0]   dividend_i,
  input  wire logic [sgk_pkg::DVSR_W-1:0]  divisor_i,
  output sgk_pkg::div_sts_t                sts_o,
  output logic [sgk_pkg::DIV_W-1:0]        quot_o
);
  import sgk_pkg::*;

  logic [DIV_W-1:0]    q_q, q_d;
  logic [DVSR_W-1:0]   r_q, r_d;
  logic [DVSR_W-1:0]   dvsr_q;
  logic [DIVCNT_W-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [DVSR_W:0]     r2;
  logic                ge;

  assign r2 = {r_q, q_q[DIV_W-1]};
  assign ge = r2 >= {1'b0, dvsr_q};

  always_comb begin
    q_d    = q_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      q_d    = req_i.wide ? dividend_i
                          : {dividend_i[DIV_NW-1:0], {(DIV_W-DIV_NW){1'b0}}};
      r_d    = '0;
      cnt_d  = req_i.wide ? DIVCNT_W'(DIV_W) : DIVCNT_W'(DIV_NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d   = ge ? DVSR_W'(r2 - {1'b0, dvsr_q}) : r2[DVSR_W-1:0];
      q_d   = {q_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - DIVCNT_W'(1);
      if (cnt_q == DIVCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    if (req_i.start) dvsr_q <= divisor_i;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = q_q;

endmodule

`default_nettype wire

>>> hw/rtl/scroll_glide_speed_keep_window_core.sv
// Wheel scroll spreader. Each event computes a keep fraction from the gap since
// the previous event (one shared multiplier, one shared serial divider) and
// stores the kept amount in a window slot, or adds it to the carry when the
// window is zero or full; each tick pays the carry plus every slot's share and
// compacts the slot memory in place. An event needs the 48-step divide only
// when interpolation is needed; a tick runs a 32-step divide for each live
// slot that is not paid out whole.
// The input is held off until the current beat is finished; a result may wait
// in the output register while the next beat is taken.
// depends on sgk_pkg, sgk_if, sgk_div
`timescale 1ns / 1ps
`default_nettype none

module scroll_glide_speed_keep_window_core #(
  parameter int unsigned ENTRIES  = 256,
  parameter int unsigned AGE_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  sgk_in_if.sink                 evt_i,
  sgk_out_if.source              res_o,
  input  wire logic              cfg_we_i,
  input  wire sgk_pkg::cfg_idx_e cfg_idx_i,
  input  wire logic [15:0]       cfg_wdata_i
);
  import sgk_pkg::*;

  localparam int unsigned IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNW = $clog2(ENTRIES + 1);
  localparam int unsigned CW  = (AGE_BITS > 16) ? AGE_BITS : 16;
  localparam int unsigned ACW = 48;

  typedef enum logic [17:0] {
    ST_IDLE  = 18'b000000000000000001,
    ST_SLOW  = 18'b000000000000000010,
    ST_SLOWW = 18'b000000000000000100,
    ST_MA    = 18'b000000000000001000,
    ST_MG    = 18'b000000000000010000,
    ST_MF    = 18'b000000000000100000,
    ST_CMP   = 18'b000000000001000000,
    ST_MD    = 18'b000000000010000000,
    ST_MN    = 18'b000000000100000000,
    ST_KDIV  = 18'b000000001000000000,
    ST_KDIVW = 18'b000000010000000000,
    ST_MK    = 18'b000000100000000000,
    ST_STORE = 18'b000001000000000000,
    ST_TRD   = 18'b000010000000000000,
    ST_TEV   = 18'b000100000000000000,
    ST_TDIVW = 18'b001000000000000000,
    ST_TWB   = 18'b010000000000000000,
    ST_DONE  = 18'b100000000000000000
  } state_e;

  state_e st_q, st_d;

  // configuration
  logic [6:0]  kin_q;
  logic [15:0] win_q, sgap_q, fgap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kin_q  <= KIN_RST;
      win_q  <= WIN_RST;
      sgap_q <= SGAP_RST;
      fgap_q <= FGAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KINETIC: kin_q  <= cfg_wdata_i[6:0];
        CFG_WINDOW:  win_q  <= cfg_wdata_i;
        CFG_SLOWGAP: sgap_q <= cfg_wdata_i;
        CFG_FASTGAP: fgap_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control state
  logic [CNW-1:0]        cnt_q, cnt_d, i_q, i_d, w_q, w_d;
  logic signed [31:0]    carry_q, carry_d;
  logic [15:0]           tse_q, tse_d;
  logic                  seen_q, seen_d;
  logic                  ov_q, ov_d;

  // datapath
  logic                  typ_q, typ_d, neg_q, neg_d;
  logic [15:0]           mag_q, mag_d;
  logic [16:0]           sq_q, sq_d, keep_q, keep_d;
  logic [31:0]           a_q, a_d, g_q, g_d, f_q, f_d, den_q, den_d;
  logic [47:0]           num_q, num_d;
  logic signed [31:0]    amt_q, amt_d, pay_q, pay_d;
  logic signed [ACW-1:0] acc_q, acc_d;
  logic signed [31:0]    o_del_q;
  logic [16:0]           o_keep_q;
  logic                  o_act_q;

  // slot memory
  logic signed [31:0]    mem_amt [ENTRIES];
  logic [AGE_BITS-1:0]   mem_age [ENTRIES];
  logic signed [31:0]    rd_amt_q;
  logic [AGE_BITS-1:0]   rd_age_q;
  logic                  we;
  logic [IW-1:0]         wa;
  logic signed [31:0]    wd_amt;
  logic [AGE_BITS-1:0]   wd_age;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_amt[wa] <= wd_amt;
      mem_age[wa] <= wd_age;
    end
    if (st_q == ST_TRD) begin
      rd_amt_q <= mem_amt[i_q[IW-1:0]];
      rd_age_q <= mem_age[i_q[IW-1:0]];
    end
  end

  // shared multiplier
  logic [31:0] mul_x;
  logic [16:0] mul_y;
  logic [48:0] mul_p;
  assign mul_p = 49'(mul_x) * 49'(mul_y);

  // shared divider
  div_req_t           dreq;
  div_sts_t           dsts;
  logic [DIV_W-1:0]   ddnd, dquot;
  logic [DVSR_W-1:0]  ddvs;

  sgk_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (dreq),
    .dividend_i (ddnd),
    .divisor_i  (ddvs),
    .sts_o      (dsts),
    .quot_o     (dquot)
  );

  // helper values
  logic [15:0]        in_mag;
  logic [32:0]        rnd;
  logic [29:0]        rmag;
  logic [32:0]        srnd;
  logic signed [32:0] csum;
  logic [CW-1:0]      age_x, win_x, left, age_n;
  logic [31:0]        amag;
  logic signed [31:0] rest;
  logic signed [ACW-1:0] acc_n;
  logic [CNW-1:0]     w_n;
  logic               keep_slot;

  assign in_mag = evt_i.event_deltas[15] ? 16'(~evt_i.event_deltas + 16'd1)
                                         : evt_i.event_deltas;
  assign rnd    = mul_p[32:0] + 33'd4;
  assign rmag   = rnd[32:3];
  assign srnd   = mul_p[32:0] + 33'd32768;
  assign csum   = 33'(carry_q) + 33'(amt_q);
  assign age_x  = CW'(rd_age_q);
  assign win_x  = CW'(win_q);
  assign left   = win_x - age_x;
  assign amag   = rd_amt_q[31] ? 32'(-rd_amt_q) : rd_amt_q;
  assign rest   = rd_amt_q - pay_q;
  assign age_n  = (rd_age_q != {AGE_BITS{1'b1}}) ? age_x + CW'(1) : age_x;
  assign acc_n  = acc_q + ACW'(pay_q);
  assign keep_slot = (age_n < win_x) && (rest != 32'sd0);
  assign w_n    = keep_slot ? w_q + CNW'(1) : w_q;

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    i_d     = i_q;
    w_d     = w_q;
    carry_d = carry_q;
    tse_d   = tse_q;
    seen_d  = seen_q;
    ov_d    = ov_q;
    typ_d   = typ_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    sq_d    = sq_q;
    keep_d  = keep_q;
    a_d     = a_q;
    g_d     = g_q;
    f_d     = f_q;
    den_d   = den_q;
    num_d   = num_q;
    amt_d   = amt_q;
    pay_d   = pay_q;
    acc_d   = acc_q;
    mul_x   = 32'(mag_q);
    mul_y   = 17'(sgap_q);
    dreq    = '0;
    ddnd    = '0;
    ddvs    = '0;
    we      = 1'b0;
    wa      = w_q[IW-1:0];
    wd_amt  = rest;
    wd_age  = age_n[AGE_BITS-1:0];

    if (res_o.valid && res_o.ready) ov_d = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (evt_i.valid) begin
          typ_d = evt_i.req_type;
          neg_d = evt_i.event_deltas[15];
          mag_d = in_mag;
          if (evt_i.req_type == REQ_TICK) begin
            if (tse_q != 16'hFFFF) tse_d = tse_q + 16'd1;
            acc_d   = ACW'(carry_q);
            carry_d = '0;
            i_d     = '0;
            w_d     = '0;
            if (win_q == 16'd0) cnt_d = '0;
            st_d = (win_q != 16'd0 && cnt_q != '0) ? ST_TRD : ST_DONE;
          end else begin
            st_d = ST_SLOW;
          end
        end
      end
      ST_SLOW: begin
        if (kin_q >= NOTCH) begin
          keep_d = ONE_Q16;
          st_d   = ST_MK;
        end else begin
          // reciprocal multiply for the rounded kin/120 fraction
          mul_x = SLOW_RECIP;
          mul_y = 17'(kin_q);
          sq_d  = srnd[32:16];
          st_d  = ST_SLOWW;
        end
      end
      ST_SLOWW: begin
        if (!seen_q || mag_q == 16'd0) begin
          keep_d = sq_q;
          st_d   = ST_MK;
        end else if (sgap_q == 16'd0) begin
          keep_d = ONE_Q16;
          st_d   = ST_MK;
        end else begin
          st_d = ST_MA;
        end
      end
      ST_MA: begin
        a_d  = mul_p[31:0];
        st_d = ST_MG;
      end
      ST_MG: begin
        mul_x = 32'(tse_q);
        mul_y = 17'(NOTCH);
        g_d   = mul_p[31:0];
        st_d  = ST_MF;
      end
      ST_MF: begin
        mul_y = 17'(fgap_q);
        f_d   = mul_p[31:0];
        st_d  = ST_CMP;
      end
      ST_CMP: begin
        if (g_q >= a_q) begin
          keep_d = sq_q;
          st_d   = ST_MK;
        end else if (g_q <= f_q) begin
          keep_d = ONE_Q16;
          st_d   = ST_MK;
        end else begin
          st_d = ST_MD;
        end
      end
      ST_MD: begin
        // slow gap is above fast gap on this path
        mul_y = 17'(sgap_q - fgap_q);
        den_d = mul_p[31:0];
        st_d  = ST_MN;
      end
      ST_MN: begin
        mul_x = a_q - g_q;
        mul_y = ONE_Q16 - sq_q;
        num_d = mul_p[47:0];
        st_d  = ST_KDIV;
      end
      ST_KDIV: begin
        dreq.start = 1'b1;
        dreq.wide  = 1'b1;
        ddnd = num_q + DIV_W'(den_q[31:1]);
        ddvs = den_q;
        st_d = ST_KDIVW;
      end
      ST_KDIVW: begin
        if (dsts.done) begin
          keep_d = sq_q + dquot[16:0];
          st_d   = ST_MK;
        end
      end
      ST_MK: begin
        mul_y = keep_q;
        amt_d = neg_q ? -32'(rmag) : 32'(rmag);
        st_d  = ST_STORE;
      end
      ST_STORE: begin
        seen_d = 1'b1;
        tse_d  = '0;
        if (amt_q != 32'sd0) begin
          if (win_q == 16'd0 || cnt_q == CNW'(ENTRIES)) begin
            if (csum > 33'sd2147483647) carry_d = 32'sh7FFFFFFF;
            else if (csum < -33'sd2147483648) carry_d = 32'sh80000000;
            else carry_d = csum[31:0];
          end else begin
            we     = 1'b1;
            wa     = cnt_q[IW-1:0];
            wd_amt = amt_q;
            wd_age = '0;
            cnt_d  = cnt_q + CNW'(1);
          end
        end
        st_d = ST_DONE;
      end
      ST_TRD: st_d = ST_TEV;
      ST_TEV: begin
        if (win_x > age_x && left > CW'(1)) begin
          dreq.start = 1'b1;
          ddnd = DIV_W'(amag);
          ddvs = DVSR_W'(left[15:0]);
          st_d = ST_TDIVW;
        end else begin
          pay_d = rd_amt_q;
          st_d  = ST_TWB;
        end
      end
      ST_TDIVW: begin
        if (dsts.done) begin
          pay_d = rd_amt_q[31] ? -dquot[31:0] : dquot[31:0];
          st_d  = ST_TWB;
        end
      end
      ST_TWB: begin
        acc_d = acc_n;
        we    = keep_slot;
        w_d   = w_n;
        i_d   = i_q + CNW'(1);
        if (i_q + CNW'(1) == cnt_q) begin
          cnt_d = w_n;
          st_d  = ST_DONE;
        end else begin
          st_d = ST_TRD;
        end
      end
      ST_DONE: begin
        if (!ov_q || res_o.ready) begin
          ov_d = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      cnt_q   <= '0;
      i_q     <= '0;
      w_q     <= '0;
      carry_q <= '0;
      tse_q   <= '0;
      seen_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      w_q     <= w_d;
      carry_q <= carry_d;
      tse_q   <= tse_d;
      seen_q  <= seen_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    typ_q  <= typ_d;
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    sq_q   <= sq_d;
    keep_q <= keep_d;
    a_q    <= a_d;
    g_q    <= g_d;
    f_q    <= f_d;
    den_q  <= den_d;
    num_q  <= num_d;
    amt_q  <= amt_d;
    pay_q  <= pay_d;
    acc_q  <= acc_d;
    if (st_q == ST_DONE && (!ov_q || res_o.ready)) begin
      if (typ_q == REQ_TICK) begin
        if (acc_q > ACW'(32'sh7FFFFFFF)) o_del_q <= 32'sh7FFFFFFF;
        else if (acc_q < -ACW'(64'sh80000000)) o_del_q <= 32'sh80000000;
        else o_del_q <= acc_q[31:0];
        o_keep_q <= '0;
      end else begin
        o_del_q  <= '0;
        o_keep_q <= keep_q;
      end
      o_act_q <= (cnt_q != '0) || (carry_q != 32'sd0);
    end
  end

  assign evt_i.ready           = (st_q == ST_IDLE);
  assign res_o.valid           = ov_q;
  assign res_o.delivered_units = o_del_q;
  assign res_o.keep_applied    = o_keep_q;
  assign res_o.still_active    = o_act_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNW'(ENTRIES))
    else $error("slot count beyond depth");

  a_wr_behind_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_TWB) |-> (w_q <= i_q) && (i_q < cnt_q))
    else $error("compaction write index passed read index");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dsts.busy |-> (st_q == ST_KDIVW || st_q == ST_TDIVW))
    else $error("divider busy outside a wait state");

  a_res_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && o_keep_q != 17'd0) |-> (o_del_q == 32'sd0))
    else $error("event beat carries delivered units");

endmodule

`default_nettype wire

>>> tb/scroll_glide_speed_keep_window_core_tb.sv
// testbench for scroll_glide_speed_keep_window_core: directed table then random events/ticks,
// every result checked against a behavioral spreader model; depends on sgk_pkg, sgk_if and the core
`timescale 1ns / 1ps

module scroll_glide_speed_keep_window_core_tb;
  import sgk_pkg::*;

  localparam int NSLOT = 256;
  localparam longint AGE_TOP = 65535;
  localparam int STALL_LIMIT = 200000;

  typedef struct {
    logic [31:0] units;
    logic [16:0] keep;
    logic        active;
  } glide_res_t;

  typedef struct {
    req_type_e   kind;
    logic [15:0] delta;
    bit          has_exp;
    glide_res_t  exp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_idx_e cfg_idx_i = CFG_KINETIC;
  logic [15:0] cfg_wdata_i = '0;

  sgk_in_if evt_ch();
  sgk_out_if res_ch();

  scroll_glide_speed_keep_window_core i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .evt_i(evt_ch.sink), .res_o(res_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow state of the spreader
  longint slot_amt[NSLOT];
  longint slot_ag[NSLOT];
  int     n_slots;
  longint carry;
  longint gap_ticks;
  bit     had_event;
  longint kin, win, sgap, fgap;

  glide_res_t pending_q[$];
  int errors = 0;
  int n_results = 0;
  int send_idle = 16, recv_idle = 69;
  int quiet = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint keep_for(longint mag);
    longint k, slow_q, a, g, num, den;
    k = (kin > 120) ? 120 : kin;
    if (k >= 120) return 65536;
    slow_q = (k * 65536 + 60) / 120;
    if (!had_event || mag == 0) return slow_q;
    if (sgap == 0) return 65536;
    a = mag * sgap;
    g = gap_ticks * 120;
    if (g >= a) return slow_q;
    if (g <= mag * fgap) return 65536;
    den = mag * (sgap - fgap);
    num = (65536 - slow_q) * (a - g);
    return slow_q + (num + den / 2) / den;
  endfunction

  function automatic glide_res_t spread_step(req_type_e kind, logic [15:0] delta);
    glide_res_t r;
    longint paid, keep, d, mag, amt, pay, rest, age, left;
    int w;
    paid = 0;
    keep = 0;
    if (kind == REQ_EVENT) begin
      d = longint'($signed(delta));
      mag = (d < 0) ? -d : d;
      keep = keep_for(mag);
      amt = (mag * 8192 * keep + 32768) >>> 16;
      if (d < 0) amt = -amt;
      had_event = 1;
      gap_ticks = 0;
      if (amt != 0) begin
        if (win == 0 || n_slots >= NSLOT) carry = clamp32(carry + amt);
        else begin
          slot_amt[n_slots] = amt;
          slot_ag[n_slots] = 0;
          n_slots++;
        end
      end
    end else begin
      w = 0;
      if (gap_ticks < 65535) gap_ticks++;
      paid = carry;
      carry = 0;
      if (win == 0) n_slots = 0;
      for (int i = 0; i < n_slots; i++) begin
        amt = slot_amt[i];
        age = slot_ag[i];
        pay = amt;
        if (win > age && win - age > 1) begin
          left = win - age;
          pay = ((amt < 0) ? -amt : amt) / left;
          if (amt < 0) pay = -pay;
        end
        paid += pay;
        rest = amt - pay;
        if (age < AGE_TOP) age++;
        if (age < win && rest != 0) begin
          slot_amt[w] = rest;
          slot_ag[w] = age;
          w++;
        end
      end
      n_slots = w;
    end
    r.units = 32'(clamp32(paid));
    r.keep = 17'(keep);
    r.active = (n_slots > 0 || carry != 0);
    return r;
  endfunction

  // result side: random stall, compare against oldest expectation
  always @(posedge clk_i) begin
    glide_res_t e;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        n_results++;
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t unexpected beat units=%h", $time, res_ch.delivered_units);
        end else begin
          e = pending_q.pop_front();
          if (res_ch.delivered_units !== e.units) begin
            errors++;
            $display("%0t delivered_units exp %h got %h", $time, e.units,
                     res_ch.delivered_units);
          end
          if (res_ch.keep_applied !== e.keep) begin
            errors++;
            $display("%0t keep_applied exp %h got %h", $time, e.keep, res_ch.keep_applied);
          end
          if (res_ch.still_active !== e.active) begin
            errors++;
            $display("%0t still_active exp %b got %b", $time, e.active, res_ch.still_active);
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog on accepted beats
  always @(posedge clk_i) begin
    if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet);
      $display("FAIL scroll_glide_speed_keep_window_core");
      $finish;
    end
  end

  task automatic send(req_type_e kind, logic [15:0] delta, bit has_exp, glide_res_t ex);
    glide_res_t p;
    while ($urandom_range(99) < send_idle) @(posedge clk_i);
    evt_ch.valid <= 1'b1;
    evt_ch.req_type <= kind;
    evt_ch.event_deltas <= delta;
    do @(posedge clk_i); while (!evt_ch.ready);
    p = spread_step(kind, delta);
    if (has_exp && (p.units !== ex.units || p.keep !== ex.keep || p.active !== ex.active)) begin
      errors++;
      $display("%0t table row disagrees with model exp %h/%h got %h/%h", $time,
               ex.units, ex.keep, p.units, p.keep);
    end
    pending_q.push_back(p);
    evt_ch.valid <= 1'b0;
    // the block is no longer ready right after it has accepted a beat
    @(posedge clk_i);
  endtask

  task automatic drain(int settle);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // registers change only with the block idle
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    drain(40 * NSLOT);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_KINETIC: kin = val[6:0];
      CFG_WINDOW:  win = val;
      CFG_SLOWGAP: sgap = val;
      default:     fgap = val;
    endcase
  endtask

  task automatic random_burst(int count);
    logic [15:0] d;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: d = 16'($urandom);
        1: d = 16'($urandom_range(0, 480)) - 16'd240;
        default: d = ($urandom_range(1) ? 16'd120 : -16'sd120);
      endcase
      if ($urandom_range(99) < 45) send(REQ_EVENT, d, 0, '{default: '0});
      else send(REQ_TICK, 16'($urandom), 0, '{default: '0});
    end
  endtask

  stim_row_t rows[$];

  function automatic stim_row_t row(req_type_e k, logic [15:0] d, bit h, logic [31:0] u,
                                    logic [16:0] kp, logic a);
    stim_row_t s;
    s.kind = k; s.delta = d; s.has_exp = h;
    s.exp.units = u; s.exp.keep = kp; s.exp.active = a;
    return s;
  endfunction

  initial begin
    evt_ch.valid = 1'b0;
    evt_ch.req_type = REQ_EVENT;
    evt_ch.event_deltas = '0;
    res_ch.ready = 1'b0;
    n_slots = 0; carry = 0; gap_ticks = 0; had_event = 0;
    kin = 12; win = 1000; sgap = 400; fgap = 100;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: tick pays nothing, first event uses slow fraction 6554
    rows.push_back(row(REQ_TICK, 16'h0, 1, 32'h0, 17'h0, 1'b0));
    rows.push_back(row(REQ_EVENT, 16'd120, 1, 32'h0, 17'd6554, 1'b1));
    rows.push_back(row(REQ_EVENT, 16'd0, 1, 32'h0, 17'd6554, 1'b1));
    rows.push_back(row(REQ_EVENT, 16'h8000, 0, '0, '0, 0));
    rows.push_back(row(REQ_EVENT, 16'h7fff, 0, '0, '0, 0));
    rows.push_back(row(REQ_EVENT, 16'hffff, 0, '0, '0, 0));
    for (int i = 0; i < 3; i++) rows.push_back(row(REQ_TICK, 16'hffff, 0, '0, '0, 0));
    rows.push_back(row(REQ_EVENT, -16'sd120, 0, '0, '0, 0));
    rows.push_back(row(REQ_EVENT, 16'd240, 0, '0, '0, 0));
    foreach (rows[i]) send(rows[i].kind, rows[i].delta, rows[i].has_exp, rows[i].exp);

    // pause until everything has arrived
    drain(0);
    random_burst(20);

    send_idle = 69; recv_idle = 16;
    // pass-through and full keep
    write_reg(CFG_WINDOW, 16'd0);
    write_reg(CFG_KINETIC, 16'd120);
    rows.delete();
    rows.push_back(row(REQ_EVENT, 16'd8, 1, 32'h0, 17'h10000, 1'b1));
    rows.push_back(row(REQ_TICK, 16'd0, 1, 32'h10000, 17'h0, 1'b0));
    rows.push_back(row(REQ_EVENT, 16'h8000, 1, 32'hffff0000 - 32'h03ff0000 + 32'h0, 17'h10000,
                       1'b1));
    rows[2].has_exp = 0;
    foreach (rows[i]) send(rows[i].kind, rows[i].delta, rows[i].has_exp, rows[i].exp);
    random_burst(10);

    write_reg(CFG_KINETIC, 16'd0);
    write_reg(CFG_WINDOW, 16'd3);
    write_reg(CFG_SLOWGAP, 16'd0);
    write_reg(CFG_FASTGAP, 16'd65535);
    random_burst(12);
    write_reg(CFG_SLOWGAP, 16'd65535);
    write_reg(CFG_FASTGAP, 16'd0);
    write_reg(CFG_KINETIC, 16'd60);
    write_reg(CFG_WINDOW, 16'd65535);
    random_burst(8);
    write_reg(CFG_WINDOW, 16'd2);   // shrinks below live ages

    send_idle = 0; recv_idle = 0;
    write_reg(CFG_SLOWGAP, 16'd400);
    write_reg(CFG_FASTGAP, 16'd20);
    write_reg(CFG_WINDOW, 16'd6);
    random_burst(40);

    drain(40 * NSLOT);
    $display("covered %0d results over pass-through, short, long and shrinking windows",
             n_results);
    $display("and slow, interpolated and full keep fractions, %0d mismatches", errors);
    if (errors == 0) $display("PASS scroll_glide_speed_keep_window_core");
    else $display("FAIL scroll_glide_speed_keep_window_core");
    $finish;
  end
endmodule
